### src/gacu_pkg.sv
// Shared types, constants and a helper function for the growth automaton cell update.
package gacu_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE_Q = 1 << FRAC_BITS;
    localparam int HALF_Q = 1 << (FRAC_BITS - 1);
    localparam int REG_MAX = 32767;

    localparam int DATA_W = 16;
    localparam int LEVEL_W = 15;
    localparam int NSUM_W = 17;
    localparam int WORK_W = 19;
    localparam int SAT_IN_W = 20;

    // The seed scale is 9 / (10 * 2^INIT_SEED_SHIFT) in units of ONE_Q.
    localparam int INIT_SEED_SHIFT = 12;

    // Floor division by ten through a reciprocal multiply, exact for dividends below 2^22.
    localparam int DIVIDEND_W = 20;
    localparam int DIV_SHIFT = 24;
    localparam int DIV_MULT = (1 << DIV_SHIFT) / 10 + 1;
    localparam int DIV_MULT_W = 21;
    localparam int PROD_W = DIVIDEND_W + DIV_MULT_W;
    localparam int QUOT_W = 17;
    localparam int DIV_BIAS_Q = 4096;
    localparam int DIV_BIAS = DIV_BIAS_Q * 10;

    localparam int GROW_FOOD_RST_I = (8 * ONE_Q + 5) / 10;
    localparam int STARVE_RST_I = (5 * ONE_Q + 5) / 10;
    localparam int CROWD_RST_I = (99 * ONE_Q + 50) / 100;
    localparam int GROW_STEP_RST_I = (ONE_Q + 5) / 10;
    localparam int EAT_STEP_RST_I = (ONE_Q + 50) / 100;
    localparam int REGROW_RST_I = (2 * ONE_Q + 500) / 1000;
    localparam int INIT_FOOD_RST_I = (8 * ONE_Q + 5) / 10;

    localparam logic [LEVEL_W-1:0] GROW_FOOD_RST =
        LEVEL_W'(GROW_FOOD_RST_I > REG_MAX ? REG_MAX : GROW_FOOD_RST_I);
    localparam logic [LEVEL_W-1:0] STARVE_RST =
        LEVEL_W'(STARVE_RST_I > REG_MAX ? REG_MAX : STARVE_RST_I);
    localparam logic [LEVEL_W-1:0] CROWD_RST =
        LEVEL_W'(CROWD_RST_I > REG_MAX ? REG_MAX : CROWD_RST_I);
    localparam logic [LEVEL_W-1:0] GROW_STEP_RST =
        LEVEL_W'(GROW_STEP_RST_I > REG_MAX ? REG_MAX : GROW_STEP_RST_I);
    localparam logic [LEVEL_W-1:0] EAT_STEP_RST =
        LEVEL_W'(EAT_STEP_RST_I > REG_MAX ? REG_MAX : EAT_STEP_RST_I);
    localparam logic [LEVEL_W-1:0] REGROW_RST =
        LEVEL_W'(REGROW_RST_I > REG_MAX ? REG_MAX : REGROW_RST_I);
    localparam logic [DATA_W-1:0] INIT_FOOD_RST =
        DATA_W'(INIT_FOOD_RST_I > REG_MAX ? REG_MAX : INIT_FOOD_RST_I);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROW_FOOD  = 3'd0,
        CFG_STARVE     = 3'd1,
        CFG_CROWD      = 3'd2,
        CFG_GROW_STEP  = 3'd3,
        CFG_EAT_STEP   = 3'd4,
        CFG_REGROW     = 3'd5,
        CFG_INIT_FOOD  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]        grow_food_level;
        logic [LEVEL_W-1:0]        starve_level;
        logic [LEVEL_W-1:0]        crowd_level;
        logic [LEVEL_W-1:0]        grow_step;
        logic [LEVEL_W-1:0]        eat_step;
        logic [LEVEL_W-1:0]        regrow_step;
        logic signed [DATA_W-1:0]  init_food;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  centre_cell;
        logic signed [DATA_W-1:0]  centre_food;
        logic signed [DATA_W-1:0]  cell_up_left;
        logic signed [DATA_W-1:0]  cell_up;
        logic signed [DATA_W-1:0]  cell_up_right;
        logic signed [DATA_W-1:0]  cell_left;
        logic signed [DATA_W-1:0]  cell_right;
        logic signed [DATA_W-1:0]  cell_down_left;
        logic signed [DATA_W-1:0]  cell_down;
        logic signed [DATA_W-1:0]  cell_down_right;
        logic                      init_now;
        logic [11:0]               seed_value;
    } in_item_t;

    typedef struct packed {
        logic signed [NSUM_W-1:0]  nsum;
        logic signed [DATA_W-1:0]  cell_amt;
        logic signed [DATA_W-1:0]  food;
        logic                      init;
        logic [DATA_W-1:0]         seed9;
    } s1_t;

    typedef struct packed {
        logic signed [WORK_W-1:0]  cell_amt;
        logic signed [WORK_W-1:0]  food;
        logic                      decay;
        logic                      init;
        logic [DIVIDEND_W-1:0]     dividend;
    } s2_t;

    typedef struct packed {
        logic signed [WORK_W-1:0]  cell_amt;
        logic signed [WORK_W-1:0]  food;
        logic                      decay;
        logic                      init;
        logic [QUOT_W-1:0]         quot;
    } s3_t;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_IN_W'(REG_MAX)) begin
            r = DATA_W'(REG_MAX);
        end else if (v < -SAT_IN_W'(REG_MAX + 1)) begin
            r = DATA_W'(-(REG_MAX + 1));
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/gacu_cfg_regs.sv
// Configuration register file with reset defaults and an indexed write port.
module gacu_cfg_regs
    import gacu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GROW_FOOD: cfg_next.grow_food_level = cfg_data[LEVEL_W-1:0];
                CFG_STARVE:    cfg_next.starve_level = cfg_data[LEVEL_W-1:0];
                CFG_CROWD:     cfg_next.crowd_level = cfg_data[LEVEL_W-1:0];
                CFG_GROW_STEP: cfg_next.grow_step = cfg_data[LEVEL_W-1:0];
                CFG_EAT_STEP:  cfg_next.eat_step = cfg_data[LEVEL_W-1:0];
                CFG_REGROW:    cfg_next.regrow_step = cfg_data[LEVEL_W-1:0];
                CFG_INIT_FOOD: cfg_next.init_food = signed'(cfg_data);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grow_food_level <= GROW_FOOD_RST;
            cfg_reg.starve_level <= STARVE_RST;
            cfg_reg.crowd_level <= CROWD_RST;
            cfg_reg.grow_step <= GROW_STEP_RST;
            cfg_reg.eat_step <= EAT_STEP_RST;
            cfg_reg.regrow_step <= REGROW_RST;
            cfg_reg.init_food <= signed'(INIT_FOOD_RST);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/gacu_nbr_sum.sv
// First pipeline stage: weighted neighbour sum and seed pre-scaling.
module gacu_nbr_sum
    import gacu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  in_item_t  up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output s1_t       dn_data
);

    logic signed [17:0] corners;
    logic signed [17:0] edges;
    logic signed [19:0] edges3;
    logic signed [20:0] total;
    s1_t                data_next;
    s1_t                data_reg;
    logic               valid_reg;

    always_comb
    begin
        corners = 18'(up_data.cell_up_left) + 18'(up_data.cell_up_right)
                + 18'(up_data.cell_down_left) + 18'(up_data.cell_down_right);
        edges = 18'(up_data.cell_up) + 18'(up_data.cell_left)
              + 18'(up_data.cell_right) + 18'(up_data.cell_down);
        edges3 = (20'(edges) <<< 1) + 20'(edges);
        total = 21'(corners) + 21'(edges3);
        data_next.nsum = NSUM_W'(total >>> 4);
        data_next.cell_amt = up_data.centre_cell;
        data_next.food = up_data.centre_food;
        data_next.init = up_data.init_now;
        data_next.seed9 = DATA_W'(DATA_W'(up_data.seed_value) * DATA_W'(9));
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data = data_reg;

endmodule

### src/gacu_rule.sv
// Second pipeline stage: grow, eat, decay decision and food regrowth.
module gacu_rule
    import gacu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  up_valid,
    output logic  up_ready,
    input  s1_t   up_data,
    output logic  dn_valid,
    input  logic  dn_ready,
    output s2_t   dn_data
);

    logic signed [WORK_W-1:0] cell_w;
    logic signed [WORK_W-1:0] food_w;
    logic signed [WORK_W-1:0] nsum_w;
    logic signed [WORK_W-1:0] half_w;
    logic signed [WORK_W-1:0] grow_lvl;
    logic signed [WORK_W-1:0] starve_lvl;
    logic signed [WORK_W-1:0] crowd_lvl;
    logic signed [WORK_W-1:0] grow_st;
    logic signed [WORK_W-1:0] eat_st;
    logic signed [WORK_W-1:0] regrow_st;
    logic signed [WORK_W-1:0] cell_grown;
    logic signed [WORK_W-1:0] food_eaten;
    logic signed [WORK_W-1:0] biased;
    logic [31:0]              init_wide;
    logic                     grow;
    s2_t                      data_next;
    s2_t                      data_reg;
    logic                     valid_reg;

    always_comb
    begin
        cell_w = WORK_W'(up_data.cell_amt);
        food_w = WORK_W'(up_data.food);
        nsum_w = WORK_W'(up_data.nsum);
        half_w = WORK_W'(HALF_Q);
        grow_lvl = signed'(WORK_W'(cfg.grow_food_level));
        starve_lvl = signed'(WORK_W'(cfg.starve_level));
        crowd_lvl = signed'(WORK_W'(cfg.crowd_level));
        grow_st = signed'(WORK_W'(cfg.grow_step));
        eat_st = signed'(WORK_W'(cfg.eat_step));
        regrow_st = signed'(WORK_W'(cfg.regrow_step));

        grow = (nsum_w > half_w || cell_w > half_w) && food_w > grow_lvl;
        cell_grown = grow ? cell_w + grow_st : cell_w;
        food_eaten = (cell_grown > half_w) ? food_w - eat_st : food_w;

        biased = cell_grown + WORK_W'(DIV_BIAS);
        init_wide = (32'(up_data.seed9) << FRAC_BITS) >> INIT_SEED_SHIFT;

        data_next.cell_amt = cell_grown;
        data_next.food = food_eaten + regrow_st;
        data_next.decay = food_eaten < starve_lvl || nsum_w > crowd_lvl;
        data_next.init = up_data.init;
        data_next.dividend = up_data.init ? init_wide[DIVIDEND_W-1:0]
                                          : DIVIDEND_W'(unsigned'(biased));
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data = data_reg;

endmodule

### src/gacu_div10.sv
// Third pipeline stage: floor division by ten through a reciprocal multiply.
module gacu_div10
    import gacu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  s2_t   up_data,
    output logic  dn_valid,
    input  logic  dn_ready,
    output s3_t   dn_data
);

    logic [PROD_W-1:0] prod;
    s3_t               data_next;
    s3_t               data_reg;
    logic              valid_reg;

    always_comb
    begin
        prod = PROD_W'(up_data.dividend) * PROD_W'(DIV_MULT);
        data_next.cell_amt = up_data.cell_amt;
        data_next.food = up_data.food;
        data_next.decay = up_data.decay;
        data_next.init = up_data.init;
        data_next.quot = prod[DIV_SHIFT +: QUOT_W];
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data = data_reg;

endmodule

### src/growth_automaton_cell_update.sv
// Top level of the growth automaton cell update: three-stage pipeline and output register.
// An input transfer passes the neighbour-sum, rule and divide registers and then the output register.
// Throughput is one item per cycle while out_stall is low; the only wide multiplier is the divide-by-ten stage.
// Each stage takes a new item whenever it is empty or its successor moves on.
// Reset clears all stage valid bits and loads the configuration registers with defaults.
// The user must write the configuration registers only while no item is in flight; the block does not enforce it.
module growth_automaton_cell_update
    import gacu_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [DATA_W-1:0]    centre_cell,
    input  logic signed [DATA_W-1:0]    centre_food,
    input  logic signed [DATA_W-1:0]    cell_up_left,
    input  logic signed [DATA_W-1:0]    cell_up,
    input  logic signed [DATA_W-1:0]    cell_up_right,
    input  logic signed [DATA_W-1:0]    cell_left,
    input  logic signed [DATA_W-1:0]    cell_right,
    input  logic signed [DATA_W-1:0]    cell_down_left,
    input  logic signed [DATA_W-1:0]    cell_down,
    input  logic signed [DATA_W-1:0]    cell_down_right,
    input  logic                        init_now,
    input  logic [11:0]                 seed_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DATA_W-1:0]    next_cell,
    output logic signed [DATA_W-1:0]    next_food
);

    cfg_t      cfg;
    in_item_t  in_item;
    logic      s1_ready;
    logic      s1_valid;
    s1_t       s1_data;
    logic      s2_ready;
    logic      s2_valid;
    s2_t       s2_data;
    logic      s3_ready;
    logic      s3_valid;
    s3_t       s3_data;
    logic      s4_ready;

    logic signed [SAT_IN_W-1:0] quot_s;
    logic signed [SAT_IN_W-1:0] cell_res;
    logic signed [SAT_IN_W-1:0] food_res;
    logic signed [DATA_W-1:0]   cell_next;
    logic signed [DATA_W-1:0]   food_next;
    logic signed [DATA_W-1:0]   cell_reg;
    logic signed [DATA_W-1:0]   food_reg;
    logic                       out_valid_reg;

    gacu_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        in_item.centre_cell = centre_cell;
        in_item.centre_food = centre_food;
        in_item.cell_up_left = cell_up_left;
        in_item.cell_up = cell_up;
        in_item.cell_up_right = cell_up_right;
        in_item.cell_left = cell_left;
        in_item.cell_right = cell_right;
        in_item.cell_down_left = cell_down_left;
        in_item.cell_down = cell_down;
        in_item.cell_down_right = cell_down_right;
        in_item.init_now = init_now;
        in_item.seed_value = seed_value;
    end

    gacu_nbr_sum u_nbr_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (s1_ready),
        .up_data  (in_item),
        .dn_valid (s1_valid),
        .dn_ready (s2_ready),
        .dn_data  (s1_data)
    );

    gacu_rule u_rule (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (s1_valid),
        .up_ready (s2_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s3_ready),
        .dn_data  (s2_data)
    );

    gacu_div10 u_div10 (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s3_ready),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_ready (s4_ready),
        .dn_data  (s3_data)
    );

    assign in_stall = !s1_ready;

    always_comb
    begin
        quot_s = signed'(SAT_IN_W'(s3_data.quot));
        if (s3_data.init)
        begin
            cell_res = quot_s;
            food_res = SAT_IN_W'(cfg.init_food);
        end
        else
        begin
            if (s3_data.decay)
            begin
                cell_res = SAT_IN_W'(s3_data.cell_amt) - (quot_s - SAT_IN_W'(DIV_BIAS_Q));
            end
            else
            begin
                cell_res = SAT_IN_W'(s3_data.cell_amt);
            end
            food_res = SAT_IN_W'(s3_data.food);
        end
        cell_next = sat16(cell_res);
        food_next = sat16(food_res);
    end

    assign s4_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s4_ready)
        begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid && s4_ready)
        begin
            cell_reg <= cell_next;
            food_reg <= food_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign next_cell = cell_reg;
    assign next_food = food_reg;

    // A full pipeline with a stalled output must hold off new input.
    a_full_stalls_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid && s2_valid && s3_valid && out_valid_reg && out_stall) |-> in_stall
    ) else $error("full pipeline accepted an input transfer");

    // An accepted input item must occupy the first stage on the next cycle.
    a_input_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid
    ) else $error("accepted input item did not reach the first stage");

    // The divide stage, when blocked by the output register, keeps its item.
    a_div_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s3_valid && !s4_ready) |=> s3_valid
    ) else $error("blocked divide stage dropped its item");

    // The biased decay dividend always lands in a narrow quotient window.
    a_quot_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s3_valid && !s3_data.init) |-> (s3_data.quot >= QUOT_W'(819) &&
                                          s3_data.quot <= QUOT_W'(10649))
    ) else $error("decay quotient out of range");

endmodule

### verif/growth_automaton_cell_update_tb.sv
// Self-checking testbench for growth_automaton_cell_update with directed and random pixels.
module growth_automaton_cell_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gacu_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES = 6;
    localparam int SETTING_SLOTS = 8;

    typedef struct packed {
        logic signed [DATA_W-1:0] cell_amt;
        logic signed [DATA_W-1:0] food;
    } pixel_out_t;

    class pixel_update_checker;
        logic [LEVEL_W-1:0]       grow_food_level;
        logic [LEVEL_W-1:0]       starve_level;
        logic [LEVEL_W-1:0]       crowd_level;
        logic [LEVEL_W-1:0]       grow_step;
        logic [LEVEL_W-1:0]       eat_step;
        logic [LEVEL_W-1:0]       regrow_step;
        logic signed [DATA_W-1:0] init_food;
        pixel_out_t               pending_pixels[$];
        int                       mismatches;

        function new();
            grow_food_level = GROW_FOOD_RST;
            starve_level = STARVE_RST;
            crowd_level = CROWD_RST;
            grow_step = GROW_STEP_RST;
            eat_step = EAT_STEP_RST;
            regrow_step = REGROW_RST;
            init_food = INIT_FOOD_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_GROW_FOOD: grow_food_level = data[LEVEL_W-1:0];
                CFG_STARVE:    starve_level = data[LEVEL_W-1:0];
                CFG_CROWD:     crowd_level = data[LEVEL_W-1:0];
                CFG_GROW_STEP: grow_step = data[LEVEL_W-1:0];
                CFG_EAT_STEP:  eat_step = data[LEVEL_W-1:0];
                CFG_REGROW:    regrow_step = data[LEVEL_W-1:0];
                CFG_INIT_FOOD: init_food = data;
                default: ;
            endcase
        endfunction

        function logic signed [DATA_W-1:0] saturate_q(longint v);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return DATA_W'(v);
        endfunction

        function pixel_out_t predict_pixel(in_item_t p);
            longint y;
            longint f;
            longint corners;
            longint edges;
            longint s;
            longint tenth;
            pixel_out_t r;
            y = longint'($signed(p.centre_cell));
            f = longint'($signed(p.centre_food));
            corners = longint'($signed(p.cell_up_left)) + longint'($signed(p.cell_up_right))
                    + longint'($signed(p.cell_down_left))
                    + longint'($signed(p.cell_down_right));
            edges = longint'($signed(p.cell_up)) + longint'($signed(p.cell_left))
                  + longint'($signed(p.cell_right)) + longint'($signed(p.cell_down));
            s = (corners + 3 * edges) >>> 4;
            if (p.init_now) begin
                r.cell_amt = saturate_q((longint'(p.seed_value) * 9 * ONE_Q) / 40960);
                r.food = init_food;
                return r;
            end
            if ((s > HALF_Q || y > HALF_Q) && f > longint'(grow_food_level))
                y = y + longint'(grow_step);
            if (y > HALF_Q)
                f = f - longint'(eat_step);
            if (f < longint'(starve_level) || s > longint'(crowd_level)) begin
                tenth = (y >= 0) ? y / 10 : -((-y + 9) / 10);
                y = y - tenth;
            end
            f = f + longint'(regrow_step);
            r.cell_amt = saturate_q(y);
            r.food = saturate_q(f);
            return r;
        endfunction

        function void note_input(in_item_t p);
            pending_pixels.push_back(predict_pixel(p));
        endfunction

        function void check_result(logic signed [DATA_W-1:0] cell_amt,
                                   logic signed [DATA_W-1:0] food);
            pixel_out_t want;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transfer with nothing expected: cell %0d food %0d",
                             $realtime, cell_amt, food);
                return;
            end
            want = pending_pixels.pop_front();
            if (want.cell_amt !== cell_amt || want.food !== food) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: next_cell exp %0d got %0d, next_food exp %0d got %0d",
                             $realtime, $signed(want.cell_amt), cell_amt,
                             $signed(want.food), food);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               pix = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [DATA_W-1:0] next_cell;
    logic signed [DATA_W-1:0] next_food;

    logic                   idle_on = 1'b1;
    int                     stall_left = 0;
    int                     cycle_count = 0;
    logic [DATA_W-1:0]      settings[SETTING_SLOTS];
    pixel_update_checker    tracker = new();

    growth_automaton_cell_update dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .centre_cell     (pix.centre_cell),
        .centre_food     (pix.centre_food),
        .cell_up_left    (pix.cell_up_left),
        .cell_up         (pix.cell_up),
        .cell_up_right   (pix.cell_up_right),
        .cell_left       (pix.cell_left),
        .cell_right      (pix.cell_right),
        .cell_down_left  (pix.cell_down_left),
        .cell_down       (pix.cell_down),
        .cell_down_right (pix.cell_down_right),
        .init_now        (pix.init_now),
        .seed_value      (pix.seed_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .next_cell       (next_cell),
        .next_food       (next_food)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL growth_automaton_cell_update");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk) begin : result_side
        int run;
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(next_cell, next_food);
        if (!idle_on) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            run = pick_gap();
            out_stall <= (run > 0);
            stall_left = (run > 0) ? run - 1 : 0;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return DATA_W'(int'($urandom_range(0, 8192)) - 1024);
        if (r < 80)
            return DATA_W'($urandom);
        if (r < 90)
            return DATA_W'($urandom_range(2000, 4150));
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return -16'sd1;
        endcase
    endfunction

    function automatic in_item_t random_pixel();
        in_item_t p;
        p.centre_cell = pick_amount();
        p.centre_food = pick_amount();
        p.cell_up_left = pick_amount();
        p.cell_up = pick_amount();
        p.cell_up_right = pick_amount();
        p.cell_left = pick_amount();
        p.cell_right = pick_amount();
        p.cell_down_left = pick_amount();
        p.cell_down = pick_amount();
        p.cell_down_right = pick_amount();
        p.init_now = ($urandom_range(0, 9) == 0);
        p.seed_value = 12'($urandom);
        return p;
    endfunction

    function automatic in_item_t uniform_pixel(logic signed [DATA_W-1:0] cell_amt,
                                               logic signed [DATA_W-1:0] food,
                                               logic signed [DATA_W-1:0] nb);
        in_item_t p;
        p.centre_cell = cell_amt;
        p.centre_food = food;
        p.cell_up_left = nb;
        p.cell_up = nb;
        p.cell_up_right = nb;
        p.cell_left = nb;
        p.cell_right = nb;
        p.cell_down_left = nb;
        p.cell_down = nb;
        p.cell_down_right = nb;
        p.init_now = 1'b0;
        p.seed_value = 12'($urandom);
        return p;
    endfunction

    task automatic send_pixel(input in_item_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pix <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_input(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings();
        drain();
        for (int i = 0; i < SETTING_SLOTS; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= settings[i];
            @(posedge clk);
            tracker.set_reg(CFG_IDX_W'(i), settings[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        in_item_t p;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(uniform_pixel(16'sd0, 16'sd0, 16'sd0));
        send_pixel(uniform_pixel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_pixel(uniform_pixel(16'sh8000, 16'sh8000, 16'sh8000));
        send_pixel(uniform_pixel(16'sd2048, 16'sd4000, 16'sd2048));
        send_pixel(uniform_pixel(16'sd2048, 16'sd4000, 16'sd2049));
        send_pixel(uniform_pixel(16'sd2049, 16'sd4000, 16'sd0));
        send_pixel(uniform_pixel(16'sd2049, 16'sd3277, 16'sd0));
        send_pixel(uniform_pixel(16'sd2049, 16'sd3278, 16'sd0));
        send_pixel(uniform_pixel(16'sd100, 16'sd2048, 16'sd0));
        send_pixel(uniform_pixel(16'sd100, 16'sd2047, 16'sd0));
        send_pixel(uniform_pixel(16'sd1000, 16'sd3000, 16'sd4055));
        send_pixel(uniform_pixel(16'sd1000, 16'sd3000, 16'sd4056));
        send_pixel(uniform_pixel(-16'sd5, 16'sd0, 16'sd0));
        send_pixel(uniform_pixel(16'sh8000, 16'sd0, 16'sd0));
        send_pixel(uniform_pixel(16'sh7FFF, 16'sh7FFF, 16'sd4000));
        send_pixel(uniform_pixel(16'sd4000, 16'sh8000, 16'sd0));
        send_pixel(uniform_pixel(16'sd0, 16'sh7FFF, 16'sh8000));
        p = uniform_pixel(16'sd0, 16'sd3000, 16'sd0);
        p.cell_up_left = -16'sd1;
        send_pixel(p);
        p = uniform_pixel(16'sd0, 16'sd3000, 16'sd0);
        p.cell_left = -16'sd1;
        send_pixel(p);
        p = uniform_pixel(16'sd1234, 16'sd1234, 16'sd1234);
        p.init_now = 1'b1;
        p.seed_value = 12'd0;
        send_pixel(p);
        p.seed_value = 12'hFFF;
        send_pixel(p);
        p = uniform_pixel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        p.init_now = 1'b1;
        p.seed_value = 12'h800;
        send_pixel(p);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            for (int i = 0; i < SETTING_SLOTS; i++)
                settings[i] = DATA_W'($urandom);
            case (phase)
                1: begin
                    for (int i = 0; i < 7; i++)
                        settings[i] = '0;
                end
                2: begin
                    for (int i = 0; i < 6; i++)
                        settings[i] = 16'hFFFF;
                    settings[CFG_INIT_FOOD] = 16'h8000;
                end
                3: begin
                    for (int i = 0; i < 6; i++)
                        settings[i] = DATA_W'($urandom_range(0, 512));
                    settings[CFG_INIT_FOOD] = 16'h7FFF;
                end
                4: begin
                    settings[CFG_GROW_FOOD] = DATA_W'($urandom_range(1024, 6144));
                    settings[CFG_STARVE] = DATA_W'($urandom_range(1024, 6144));
                    settings[CFG_CROWD] = DATA_W'($urandom_range(1024, 6144));
                    settings[CFG_GROW_STEP] = DATA_W'($urandom_range(0, 800));
                    settings[CFG_EAT_STEP] = DATA_W'($urandom_range(0, 800));
                    settings[CFG_REGROW] = DATA_W'($urandom_range(0, 800));
                    settings[CFG_INIT_FOOD] = DATA_W'($urandom_range(0, 8192));
                end
                default: ;
            endcase
            if (phase != 0)
                apply_settings();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0)
                    idle_on <= ($urandom_range(0, 3) != 0);
                send_pixel(random_pixel());
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0)
            $display("PASS growth_automaton_cell_update");
        else
            $display("FAIL growth_automaton_cell_update");
        $finish;
    end

endmodule

### filelist.f
src/gacu_pkg.sv
src/gacu_cfg_regs.sv
src/gacu_nbr_sum.sv
src/gacu_rule.sv
src/gacu_div10.sv
src/growth_automaton_cell_update.sv
verif/growth_automaton_cell_update_tb.sv
